FILE: rtl/lobm_pkg.sv
// shared types and constants for the limit order book matcher
package lobm_pkg;

  localparam int OrderSlotsDef = 64;
  localparam int MaxTrades = 63;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_MISSING   = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_t;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  // one slot entry as kept in the memory
  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] id;
    logic [31:0] stamp;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_CMD,
    ST_MSCAN,
    ST_MSCAN_LAST,
    ST_MDECIDE,
    ST_MRD_ASK,
    ST_MWR,
    ST_MWR_BID,
    ST_TRADE_OUT,
    ST_STATUS_OUT
  } state_t;

endpackage

FILE: rtl/lobm_if.sv
// valid/ready channel interface carrying a generic payload
interface lobm_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lobm_ram.sv
// generic single-port ram with registered read
module lobm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/limit_order_book_matcher.sv
// top level: order book matcher around one slot memory
//
//  channel | dir | payload
//  in_     | in  | cmd, oid, side, price, quantity
//  out_    | out | kind, buy_id, sell_id, trade_price, trade_quantity, last,
//          |     | best_bid, best_ask, trades_total
//
// a command first sweeps the slot memory to find the id and the lowest free
// slot, applies it, then sweeps for best bid and ask and decides; with no
// trade the status beat comes next. each trade adds a bid read, ask read and
// write, bid write, trade beat, then a new sweep. in_ready stays low until the
// status beat leaves. reset is synchronous and clears valid flags and the
// arrival and trade counters; a stalled output holds the fsm.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = OrderSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_oid,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_buy_id,
  output logic [31:0] out_sell_id,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic        out_last,
  output logic [31:0] out_best_bid,
  output logic [31:0] out_best_ask,
  output logic [31:0] out_trades_total
);
  localparam int AW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  state_t state_r, state_nxt;

  // valid flags per slot
  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;

  // latched command
  logic        cmd_r;
  logic [31:0] id_r, price_r, qty_r;
  logic        side_r;

  logic [31:0] arrival_r, arrival_nxt;
  logic [31:0] trades_r, trades_nxt;
  logic [5:0]  ntr_r, ntr_nxt;
  logic [2:0]  status_r, status_nxt;

  // scan bookkeeping
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] rd_idx_r;
  logic          found_r, found_nxt;
  logic [AW-1:0] found_idx_r, found_idx_nxt;
  logic          free_ok_r, free_ok_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;

  // best trackers
  logic          bb_ok_r, bb_ok_nxt, ba_ok_r, ba_ok_nxt;
  logic [AW-1:0] bb_idx_r, bb_idx_nxt, ba_idx_r, ba_idx_nxt;
  logic [31:0]   bb_px_r, bb_px_nxt, ba_px_r, ba_px_nxt;
  logic [31:0]   bb_age_r, bb_age_nxt, ba_age_r, ba_age_nxt;

  // held bid and ask entries during update
  slot_t bid_e_r, bid_e_nxt;
  slot_t ask_e_r, ask_e_nxt;
  logic [31:0] fill_r, fill_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [2:0]  o_kind_r, o_kind_nxt;
  logic [31:0] o_buy_r, o_buy_nxt, o_sell_r, o_sell_nxt;
  logic [31:0] o_px_r, o_px_nxt, o_qty_r, o_qty_nxt;
  logic        o_last_r, o_last_nxt;
  logic [31:0] o_bb_r, o_bb_nxt, o_ba_r, o_ba_nxt, o_tt_r, o_tt_nxt;

  // memory port
  logic          we;
  logic [AW-1:0] addr;
  slot_t         wdata, rdata;

  lobm_ram #(.Width(SlotW), .Depth(ORDER_SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_ready           = (state_r == ST_IDLE) && !ov_r;
  assign out_valid          = ov_r;
  assign out_kind           = o_kind_r;
  assign out_buy_id         = o_buy_r;
  assign out_sell_id        = o_sell_r;
  assign out_trade_price    = o_px_r;
  assign out_trade_quantity = o_qty_r;
  assign out_last           = o_last_r;
  assign out_best_bid       = o_bb_r;
  assign out_best_ask       = o_ba_r;
  assign out_trades_total   = o_tt_r;

  // sequential state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      arrival_r <= '0;
      trades_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      arrival_r <= arrival_nxt;
      trades_r  <= trades_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_cmd;
      id_r    <= in_oid;
      side_r  <= in_side;
      price_r <= in_price;
      qty_r   <= in_quantity;
    end
    rd_idx_r    <= addr;
    cnt_r       <= cnt_nxt;
    ntr_r       <= ntr_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    free_ok_r   <= free_ok_nxt;
    free_idx_r  <= free_idx_nxt;
    bb_ok_r     <= bb_ok_nxt;
    ba_ok_r     <= ba_ok_nxt;
    bb_idx_r    <= bb_idx_nxt;
    ba_idx_r    <= ba_idx_nxt;
    bb_px_r     <= bb_px_nxt;
    ba_px_r     <= ba_px_nxt;
    bb_age_r    <= bb_age_nxt;
    ba_age_r    <= ba_age_nxt;
    bid_e_r     <= bid_e_nxt;
    ask_e_r     <= ask_e_nxt;
    fill_r      <= fill_nxt;
    o_kind_r    <= o_kind_nxt;
    o_buy_r     <= o_buy_nxt;
    o_sell_r    <= o_sell_nxt;
    o_px_r      <= o_px_nxt;
    o_qty_r     <= o_qty_nxt;
    o_last_r    <= o_last_nxt;
    o_bb_r      <= o_bb_nxt;
    o_ba_r      <= o_ba_nxt;
    o_tt_r      <= o_tt_nxt;
  end

  // comparisons on the entry coming out of the memory
  logic        rd_valid;
  logic [31:0] rd_age;
  logic        take_bid, take_ask;
  logic [31:0] fill_cur;
  logic [31:0] bid_left, ask_left;

  always_comb begin
    rd_valid = valid_r[rd_idx_r];
    rd_age   = arrival_r - rdata.stamp;
    take_bid = rd_valid && rdata.side == SIDE_BUY &&
               (!bb_ok_r || rdata.price > bb_px_r ||
                (rdata.price == bb_px_r && rd_age > bb_age_r));
    take_ask = rd_valid && rdata.side == SIDE_SELL &&
               (!ba_ok_r || rdata.price < ba_px_r ||
                (rdata.price == ba_px_r && rd_age > ba_age_r));
    fill_cur = (bid_e_r.quantity < rdata.quantity) ? bid_e_r.quantity
                                                   : rdata.quantity;
    ask_left = rdata.quantity - fill_cur;
    bid_left = bid_e_r.quantity - fill_r;
  end

  // control sequencer
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    arrival_nxt   = arrival_r;
    trades_nxt    = trades_r;
    cnt_nxt       = cnt_r;
    ntr_nxt       = ntr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    bb_ok_nxt     = bb_ok_r;
    ba_ok_nxt     = ba_ok_r;
    bb_idx_nxt    = bb_idx_r;
    ba_idx_nxt    = ba_idx_r;
    bb_px_nxt     = bb_px_r;
    ba_px_nxt     = ba_px_r;
    bb_age_nxt    = bb_age_r;
    ba_age_nxt    = ba_age_r;
    bid_e_nxt     = bid_e_r;
    ask_e_nxt     = ask_e_r;
    fill_nxt      = fill_r;
    ov_nxt        = ov_r;
    o_kind_nxt    = o_kind_r;
    o_buy_nxt     = o_buy_r;
    o_sell_nxt    = o_sell_r;
    o_px_nxt      = o_px_r;
    o_qty_nxt     = o_qty_r;
    o_last_nxt    = o_last_r;
    o_bb_nxt      = o_bb_r;
    o_ba_nxt      = o_ba_r;
    o_tt_nxt      = o_tt_r;
    we            = 1'b0;
    addr          = '0;
    wdata         = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          ntr_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end
      // id lookup sweep; read issued this cycle, checked next
      ST_SCAN, ST_SCAN_LAST: begin
        if (state_r == ST_SCAN_LAST || cnt_r != '0) begin
          if (rd_valid && rdata.id == id_r && !found_r) begin
            found_nxt     = 1'b1;
            found_idx_nxt = rd_idx_r;
          end
          if (!rd_valid && !free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (state_r == ST_SCAN_LAST) begin
          state_nxt = ST_CMD;
        end else begin
          addr    = cnt_r[AW-1:0];
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(ORDER_SLOTS - 1)) begin
            state_nxt = ST_SCAN_LAST;
          end
        end
      end
      // apply add or cancel
      ST_CMD: begin
        if (cmd_r == CMD_CANCEL) begin
          if (found_r) begin
            valid_nxt[found_idx_r] = 1'b0;
            status_nxt = KIND_CANCELLED;
          end else begin
            status_nxt = KIND_MISSING;
          end
        end else if (qty_r == '0 || found_r || !free_ok_r) begin
          status_nxt = KIND_REJECTED;
        end else begin
          we                      = 1'b1;
          addr                    = free_idx_r;
          wdata.side              = side_r;
          wdata.price             = price_r;
          wdata.quantity          = qty_r;
          wdata.id                = id_r;
          wdata.stamp             = arrival_r;
          valid_nxt[free_idx_r]   = 1'b1;
          arrival_nxt             = arrival_r + 32'd1;
          status_nxt              = KIND_DONE;
        end
        cnt_nxt   = '0;
        bb_ok_nxt = 1'b0;
        ba_ok_nxt = 1'b0;
        state_nxt = ST_MSCAN;
      end
      // best bid / best ask sweep
      ST_MSCAN, ST_MSCAN_LAST: begin
        if (state_r == ST_MSCAN_LAST || cnt_r != '0) begin
          if (take_bid) begin
            bb_ok_nxt  = 1'b1;
            bb_idx_nxt = rd_idx_r;
            bb_px_nxt  = rdata.price;
            bb_age_nxt = rd_age;
          end
          if (take_ask) begin
            ba_ok_nxt  = 1'b1;
            ba_idx_nxt = rd_idx_r;
            ba_px_nxt  = rdata.price;
            ba_age_nxt = rd_age;
          end
        end
        if (state_r == ST_MSCAN_LAST) begin
          state_nxt = ST_MDECIDE;
        end else begin
          addr    = cnt_r[AW-1:0];
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(ORDER_SLOTS - 1)) begin
            state_nxt = ST_MSCAN_LAST;
          end
        end
      end
      // crossed book below the trade cap: read the bid entry, else report status
      ST_MDECIDE: begin
        if (bb_ok_r && ba_ok_r && bb_px_r >= ba_px_r && ntr_r != 6'(MaxTrades)) begin
          addr      = bb_idx_r;
          state_nxt = ST_MRD_ASK;
        end else begin
          state_nxt = ST_STATUS_OUT;
        end
      end
      // bid entry arrives, read the ask entry
      ST_MRD_ASK: begin
        bid_e_nxt = rdata;
        addr      = ba_idx_r;
        state_nxt = ST_MWR;
      end
      // ask entry arrives: compute fill, write back ask
      ST_MWR: begin
        fill_nxt       = fill_cur;
        ask_e_nxt      = rdata;
        we             = 1'b1;
        addr           = ba_idx_r;
        wdata          = rdata;
        wdata.quantity = ask_left;
        if (ask_left == '0) begin
          valid_nxt[ba_idx_r] = 1'b0;
        end
        state_nxt = ST_MWR_BID;
      end
      // write back bid and count the trade
      ST_MWR_BID: begin
        we             = 1'b1;
        addr           = bb_idx_r;
        wdata          = bid_e_r;
        wdata.quantity = bid_left;
        if (bid_left == '0) begin
          valid_nxt[bb_idx_r] = 1'b0;
        end
        trades_nxt = trades_r + 32'd1;
        ntr_nxt    = ntr_r + 6'd1;
        state_nxt  = ST_TRADE_OUT;
      end
      // emit the trade beat and start the next round
      ST_TRADE_OUT: begin
        if (!ov_nxt) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = KIND_TRADE;
          o_buy_nxt  = bid_e_r.id;
          o_sell_nxt = ask_e_r.id;
          o_px_nxt   = ask_e_r.price;
          o_qty_nxt  = fill_r;
          o_last_nxt = 1'b0;
          o_bb_nxt   = '0;
          o_ba_nxt   = '0;
          o_tt_nxt   = trades_r;
          cnt_nxt    = '0;
          bb_ok_nxt  = 1'b0;
          ba_ok_nxt  = 1'b0;
          state_nxt  = ST_MSCAN;
        end
      end
      ST_STATUS_OUT: begin
        if (!ov_nxt) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = status_r;
          o_buy_nxt  = '0;
          o_sell_nxt = '0;
          o_px_nxt   = '0;
          o_qty_nxt  = '0;
          o_last_nxt = 1'b1;
          o_bb_nxt   = bb_ok_r ? bb_px_r : '0;
          o_ba_nxt   = ba_ok_r ? ba_px_r : '0;
          o_tt_nxt   = trades_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: tb/limit_order_book_matcher_tb.sv
// testbench for the limit order book matcher: random and directed commands checked against a book model
module limit_order_book_matcher_tb;
  import lobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = OrderSlotsDef;

  typedef struct packed {
    logic        cmd;
    logic [31:0] oid;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } order_cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        last;
    logic [31:0] best_bid;
    logic [31:0] best_ask;
    logic [31:0] trades_total;
  } book_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lobm_if #(.payload_t(order_cmd_t)) cmd_ch ();
  lobm_if #(.payload_t(book_event_t)) evt_ch ();

  limit_order_book_matcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready),
    .in_cmd(cmd_ch.data.cmd), .in_oid(cmd_ch.data.oid),
    .in_side(cmd_ch.data.side), .in_price(cmd_ch.data.price),
    .in_quantity(cmd_ch.data.quantity),
    .out_valid(evt_ch.valid), .out_ready(evt_ch.ready),
    .out_kind(evt_ch.data.kind), .out_buy_id(evt_ch.data.buy_id),
    .out_sell_id(evt_ch.data.sell_id), .out_trade_price(evt_ch.data.trade_price),
    .out_trade_quantity(evt_ch.data.trade_quantity), .out_last(evt_ch.data.last),
    .out_best_bid(evt_ch.data.best_bid), .out_best_ask(evt_ch.data.best_ask),
    .out_trades_total(evt_ch.data.trades_total)
  );

  always #10 clk = ~clk;

  // model copy of the book
  logic        bk_valid[Slots];
  logic        bk_side[Slots];
  logic [31:0] bk_price[Slots];
  logic [31:0] bk_qty[Slots];
  logic [31:0] bk_id[Slots];
  logic [31:0] bk_stamp[Slots];
  logic [31:0] arrivals;
  logic [31:0] trade_count;

  order_cmd_t  pending_cmds[$];
  book_event_t expected_events[$];
  int errors = 0;
  int cmds_sent = 0;
  int events_seen = 0;
  int trades_seen = 0;
  bit busy_mode = 1'b0;

  // best resting order of one side by price, then by age
  function automatic int best_slot(logic want_sell);
    int best;
    logic [31:0] best_px, best_age, age;
    bit take;
    best = -1;
    best_px = '0;
    best_age = '0;
    for (int i = 0; i < Slots; i++) begin
      if (bk_valid[i] && bk_side[i] == want_sell) begin
        age = arrivals - bk_stamp[i];
        if (best < 0) take = 1'b1;
        else if (bk_price[i] != best_px)
          take = want_sell ? (bk_price[i] < best_px) : (bk_price[i] > best_px);
        else take = age > best_age;
        if (take) begin
          best = i;
          best_px = bk_price[i];
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic int slot_of_id(logic [31:0] id);
    for (int i = 0; i < Slots; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // apply one command to the model book and queue the events it causes
  function automatic void book_apply(order_cmd_t c);
    kind_t status;
    int s, free_slot, b, a, n;
    logic [31:0] fill;
    book_event_t ev;
    n = 0;
    if (c.cmd == CMD_CANCEL) begin
      s = slot_of_id(c.oid);
      if (s >= 0) begin
        bk_valid[s] = 1'b0;
        status = KIND_CANCELLED;
      end else begin
        status = KIND_MISSING;
      end
    end else begin
      free_slot = -1;
      for (int i = Slots - 1; i >= 0; i--)
        if (!bk_valid[i]) free_slot = i;
      if (c.quantity == 0 || slot_of_id(c.oid) >= 0 || free_slot < 0) begin
        status = KIND_REJECTED;
      end else begin
        bk_valid[free_slot] = 1'b1;
        bk_side[free_slot] = c.side;
        bk_price[free_slot] = c.price;
        bk_qty[free_slot] = c.quantity;
        bk_id[free_slot] = c.oid;
        bk_stamp[free_slot] = arrivals;
        arrivals++;
        status = KIND_DONE;
      end
    end
    // match rounds, capped per command
    while (n < MaxTrades) begin
      b = best_slot(SIDE_BUY);
      a = best_slot(SIDE_SELL);
      if (b < 0 || a < 0 || bk_price[b] < bk_price[a]) break;
      fill = (bk_qty[b] < bk_qty[a]) ? bk_qty[b] : bk_qty[a];
      trade_count++;
      ev = '0;
      ev.kind = KIND_TRADE;
      ev.buy_id = bk_id[b];
      ev.sell_id = bk_id[a];
      ev.trade_price = bk_price[a];
      ev.trade_quantity = fill;
      ev.trades_total = trade_count;
      expected_events.push_back(ev);
      n++;
      bk_qty[b] -= fill;
      bk_qty[a] -= fill;
      if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
      if (bk_qty[a] == 0) bk_valid[a] = 1'b0;
    end
    b = best_slot(SIDE_BUY);
    a = best_slot(SIDE_SELL);
    ev = '0;
    ev.kind = status;
    ev.last = 1'b1;
    ev.best_bid = (b >= 0) ? bk_price[b] : '0;
    ev.best_ask = (a >= 0) ? bk_price[a] : '0;
    ev.trades_total = trade_count;
    expected_events.push_back(ev);
  endfunction

  function automatic int draw_wait();
    return busy_mode ? 0 : $urandom_range(0, 6);
  endfunction

  // driver: present queued commands with random gaps
  int cmd_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        book_apply(cmd_ch.data);
        cmds_sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_gap > 0) begin
          cmd_gap <= cmd_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_ch.data <= pending_cmds[0];
          pending_cmds.delete(0);
          cmd_ch.valid <= 1'b1;
          cmd_gap <= draw_wait();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expected event
  int evt_stall = 0;
  always @(posedge clk) begin
    book_event_t got, want;
    if (!rst_n) begin
      evt_ch.ready <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        got = evt_ch.data;
        events_seen++;
        if (got.kind == KIND_TRADE) trades_seen++;
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = expected_events[0];
          expected_events.delete(0);
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      // random backpressure
      if (evt_stall > 0) begin
        evt_stall <= evt_stall - 1;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= 1'b1;
        if (evt_ch.valid && evt_ch.ready) evt_stall <= draw_wait();
      end
    end
  end

  function automatic order_cmd_t mk(logic cmd, logic [31:0] id, logic side,
                                    logic [31:0] px, logic [31:0] qty);
    order_cmd_t c;
    c.cmd = cmd;
    c.oid = id;
    c.side = side;
    c.price = px;
    c.quantity = qty;
    return c;
  endfunction

  logic [31:0] id_pool[24];

  initial begin
    order_cmd_t c;
    int r;
    for (int i = 0; i < Slots; i++) bk_valid[i] = 1'b0;
    arrivals = '0;
    trade_count = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    evt_ch.ready = 1'b0;
    for (int i = 0; i < 24; i++) id_pool[i] = $urandom();

    // directed: resting, time priority, rejects, cancels, price extremes
    pending_cmds.push_back(mk(CMD_ADD, 32'd1, SIDE_BUY, 32'd100, 32'd10));
    pending_cmds.push_back(mk(CMD_ADD, 32'd2, SIDE_SELL, 32'd101, 32'd5));
    pending_cmds.push_back(mk(CMD_ADD, 32'd3, SIDE_SELL, 32'd101, 32'd3));
    pending_cmds.push_back(mk(CMD_ADD, 32'd4, SIDE_BUY, 32'd101, 32'd6));
    pending_cmds.push_back(mk(CMD_ADD, 32'd7, SIDE_BUY, 32'd90, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD, 32'd1, SIDE_SELL, 32'd90, 32'd4));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd99, SIDE_SELL, 32'hFFFF_FFFF, 32'd1));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd1, SIDE_SELL, 32'h1234_5678, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD, 32'd5, SIDE_BUY, 32'd0, 32'd8));
    pending_cmds.push_back(mk(CMD_ADD, 32'd6, SIDE_SELL, 32'd0, 32'd2));
    pending_cmds.push_back(mk(CMD_ADD, 32'hFFFF_FFFF, SIDE_BUY, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF));
    pending_cmds.push_back(mk(CMD_ADD, 32'd0, SIDE_SELL, 32'hFFFF_FFFF, 32'd1));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'hFFFF_FFFF, SIDE_BUY, 32'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd3, SIDE_BUY, 32'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd5, SIDE_BUY, 32'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd5, SIDE_BUY, 32'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD, 32'd8, SIDE_SELL, 32'd200, 32'd7));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd8, SIDE_SELL, 32'd0, 32'd0));

    // fill the store, one add over capacity, free a slot, then a sweep up to the trade cap
    for (int i = 0; i < Slots; i++)
      pending_cmds.push_back(mk(CMD_ADD, 32'd1000 + i, SIDE_BUY,
                                32'd50 + $urandom_range(0, 7), $urandom_range(1, 3)));
    pending_cmds.push_back(mk(CMD_ADD, 32'd2000, SIDE_SELL, 32'd500, 32'd1));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd1000, SIDE_BUY, 32'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD, 32'd3000, SIDE_SELL, 32'd0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(CMD_CANCEL, 32'd3000, SIDE_SELL, 32'd0, 32'd0));

    // random: mostly crossing prices near one level, some extremes
    for (int k = 0; k < 25; k++) begin
      c.cmd = ($urandom_range(0, 9) < 3) ? CMD_CANCEL : CMD_ADD;
      c.oid = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 23)]
                                          : $urandom();
      c.side = $urandom_range(0, 1);
      r = $urandom_range(0, 9);
      if (r < 8) c.price = 32'd1000 + $urandom_range(0, 10) - 5;
      else if (r == 8) c.price = $urandom();
      else c.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      c.quantity = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom();
      pending_cmds.push_back(c);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // alternate stretches of random idling and none
    while (pending_cmds.size() > 0 || cmd_ch.valid) begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      busy_mode = ~busy_mode;
    end
    busy_mode = 1'b0;
    while (expected_events.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d commands, %0d result beats, %0d trades", cmds_sent,
             events_seen, trades_seen);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d, events left: %0d", errors, expected_events.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60ms;
    $display("timeout with %0d events outstanding", expected_events.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: limit_order_book_matcher.f
rtl/lobm_pkg.sv
rtl/lobm_if.sv
rtl/lobm_ram.sv
rtl/limit_order_book_matcher.sv
tb/limit_order_book_matcher_tb.sv
